@@ sv/pkat_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pkat_pkg: shared types and constants
// Request and result formats, table geometry and the table entry layout.
// ----------------------------------------------------------------------------
package pkat_pkg;

	localparam int KEY_BITS   = 12;
	localparam int ID_BITS    = 12;
	localparam int WORD_BITS  = 32;
	localparam int DIV_STEPS  = WORD_BITS;
	localparam int STEP_BITS  = $clog2(DIV_STEPS);

	typedef logic [KEY_BITS-1:0]  key_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_QUERY  = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t              opcode;
		logic [ID_BITS-1:0]   message_id;
		word_t                duration;
	} request_t;

	typedef struct packed {
		word_t average;
		logic  found;
	} result_t;

	typedef struct packed {
		logic  valid;
		word_t count;
		word_t average;
	} entry_t;

	localparam word_t COUNT_MAX = {WORD_BITS{1'b1}};
	localparam word_t COUNT_ONE = word_t'(1);

endpackage
`default_nettype wire

@@ sv/pkat_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pkat_table: per-key entry storage
// Valid, count and average memories with registered reads. After reset a
// clearing pass walks the valid memory once; ready is low until it ends.
// ----------------------------------------------------------------------------
module pkat_table (
	input  wire                  clk,
	input  wire                  arst_n,
	output logic                 ready,
	input  wire                  rd_en,
	input  wire  pkat_pkg::key_t rd_addr,
	output pkat_pkg::entry_t     rd_data,
	input  wire                  wr_en,
	input  wire  pkat_pkg::key_t wr_addr,
	input  wire  pkat_pkg::word_t wr_count,
	input  wire  pkat_pkg::word_t wr_average
);
	import pkat_pkg::*;

	localparam int DEPTH = 1 << KEY_BITS;

	logic  valid_mem [DEPTH];
	word_t count_mem [DEPTH];
	word_t avg_mem   [DEPTH];

	logic [KEY_BITS:0] clr_q;

	assign ready = clr_q[KEY_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[KEY_BITS]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_q[KEY_BITS]) begin
			valid_mem[clr_q[KEY_BITS-1:0]] <= 1'b0;
		end else if (wr_en) begin
			valid_mem[wr_addr] <= 1'b1;
		end
		if (wr_en) begin
			count_mem[wr_addr] <= wr_count;
			avg_mem[wr_addr]   <= wr_average;
		end
		if (rd_en) begin
			rd_data.valid   <= valid_mem[rd_addr];
			rd_data.count   <= count_mem[rd_addr];
			rd_data.average <= avg_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ sv/pkat_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pkat_divider: iterative restoring divider
// Divides a 64-bit dividend by a 33-bit divisor, one quotient bit a cycle.
// The upper half of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module pkat_divider (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire  [2*pkat_pkg::WORD_BITS-1:0]      dividend,
	input  wire  [pkat_pkg::WORD_BITS:0]          divisor,
	output logic                                  done,
	output pkat_pkg::word_t                       quotient
);
	import pkat_pkg::*;

	logic                  run_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [WORD_BITS:0]    rem_q;
	word_t                 low_q;
	logic [WORD_BITS:0]    div_q;

	logic [WORD_BITS+1:0]  trial;
	logic [WORD_BITS+1:0]  diff;
	logic                  qbit;
	logic [WORD_BITS:0]    rem_next;

	always_comb begin
		trial    = {rem_q, low_q[WORD_BITS-1]};
		diff     = trial - {1'b0, div_q};
		qbit     = !diff[WORD_BITS+1];
		rem_next = qbit ? diff[WORD_BITS:0] : trial[WORD_BITS:0];
	end

	assign done     = run_q && (step_q == STEP_BITS'(DIV_STEPS - 1));
	assign quotient = {low_q[WORD_BITS-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 1'b1;
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[2*WORD_BITS-1:WORD_BITS]};
			low_q <= dividend[WORD_BITS-1:0];
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_next;
			low_q <= quotient;
		end
	end

endmodule
`default_nettype wire

@@ sv/per_key_running_average_table_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// per_key_running_average_table_top: per-key cumulative average table
// Keeps a sample count and a truncated running average for each message id.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// A record request adds a duration sample to the entry of its message id; a
// query request returns the stored average, or zero for an unseen id. Every
// request gives one result, shown on result for one cycle with done high;
// found tells whether the entry existed before the request. The receiver
// cannot stall, so the result is lost if it is not taken in that cycle.
// A query, or a record on an unseen id, gives its result from the look-up
// state, once the registered table read is back. A record on a known id
// multiplies the stored average by the count, adds the duration and divides
// by count plus one in a bit-serial divider; its result comes when the
// divider is done. Busy stays high until the result is out, so one
// request is in flight at a time.
// After reset the valid marks of all 4096 entries are cleared, one a cycle;
// busy stays high until that clearing pass ends.
// ----------------------------------------------------------------------------
module per_key_running_average_table_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire  pkat_pkg::request_t request,
	output logic                 done,
	output pkat_pkg::result_t    result
);
	import pkat_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MUL,
		ST_DIV
	} state_t;

	state_t state_q;
	opcode_t opcode_q;
	key_t    key_q;
	word_t   dur_q;
	word_t   cnt_q;
	logic [2*WORD_BITS-1:0] prod_q;

	logic   tbl_ready;
	entry_t rd_data;
	logic   accept;
	logic   tbl_wr;
	word_t  wr_count;
	word_t  wr_average;
	logic   div_start;
	logic   div_done;
	word_t  quotient;
	word_t  cnt_next;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE) || !tbl_ready;

	assign cnt_next = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_ONE;

	always_comb begin
		tbl_wr     = 1'b0;
		wr_count   = COUNT_ONE;
		wr_average = dur_q;
		if (state_q == ST_LOOK && opcode_q == OP_RECORD && !rd_data.valid) begin
			tbl_wr = 1'b1;
		end else if (state_q == ST_DIV && div_done) begin
			tbl_wr     = 1'b1;
			wr_count   = cnt_next;
			wr_average = quotient;
		end
	end

	assign div_start = (state_q == ST_MUL);

	pkat_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.ready      (tbl_ready),
		.rd_en      (accept),
		.rd_addr    (key_t'(request.message_id)),
		.rd_data    (rd_data),
		.wr_en      (tbl_wr),
		.wr_addr    (key_q),
		.wr_count   (wr_count),
		.wr_average (wr_average)
	);

	pkat_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q + {{WORD_BITS{1'b0}}, dur_q}),
		.divisor  ({1'b0, cnt_q} + {{WORD_BITS{1'b0}}, 1'b1}),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (opcode_q == OP_RECORD && rd_data.valid) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= request.opcode;
			key_q    <= key_t'(request.message_id);
			dur_q    <= request.duration;
		end
		if (state_q == ST_LOOK) begin
			cnt_q          <= rd_data.count;
			prod_q         <= (2*WORD_BITS)'(rd_data.average) *
				(2*WORD_BITS)'(rd_data.count);
			result.found   <= rd_data.valid;
			if (opcode_q == OP_RECORD) begin
				result.average <= rd_data.valid ? rd_data.average : dur_q;
			end else begin
				result.average <= rd_data.valid ? rd_data.average : '0;
			end
		end else if (state_q == ST_DIV && div_done) begin
			result.average <= quotient;
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("request not held busy after acceptance");

	a_write_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr |-> tbl_ready)
		else $error("table write during clearing pass");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside of divide state");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr |=> done)
		else $error("table write without a result");

endmodule
`default_nettype wire

@@ sim/per_key_running_average_table_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_running_average_table_top_tb: running average table testbench
// Sends record and query requests to the per-key average table and checks
// every result against a cycle-free prediction of the count/average table.
// A directed opening covers extreme ids and durations, unseen ids and
// truncation; a random part then keeps most traffic on a few hot ids so that
// entries build up long sample histories, with sender idle bursts.
// ----------------------------------------------------------------------------
module per_key_running_average_table_top_tb;

	import pkat_pkg::*;

	class running_average_checker;
		bit        entry_seen [1 << KEY_BITS];
		word_t     sample_count [1 << KEY_BITS];
		word_t     mean [1 << KEY_BITS];
		result_t   expected_results [$];
		int unsigned failures;

		function void note_request(request_t r);
			key_t        slot;
			result_t     res;
			logic [63:0] total;
			logic [63:0] quotient;
			slot = key_t'(r.message_id);
			res.found = entry_seen[slot];
			res.average = '0;
			if (r.opcode == OP_RECORD) begin
				if (!entry_seen[slot]) begin
					entry_seen[slot] = 1'b1;
					sample_count[slot] = COUNT_ONE;
					mean[slot] = r.duration;
				end else begin
					total = 64'(mean[slot]) * 64'(sample_count[slot]) + 64'(r.duration);
					quotient = total / (64'(sample_count[slot]) + 64'd1);
					mean[slot] = quotient[WORD_BITS-1:0];
					if (sample_count[slot] != COUNT_MAX)
						sample_count[slot] = sample_count[slot] + COUNT_ONE;
				end
				res.average = mean[slot];
			end else if (entry_seen[slot]) begin
				res.average = mean[slot];
			end
			expected_results.push_back(res);
		endfunction

		function void report_failure(string what);
			failures++;
			if (failures <= 10)
				$display("%0t: mismatch: %s", $time, what);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report_failure($sformatf("unexpected result average=%h found=%b",
					got.average, got.found));
				return;
			end
			want = expected_results.pop_front();
			if (got.average !== want.average)
				report_failure($sformatf("average expected %h actual %h",
					want.average, got.average));
			if (got.found !== want.found)
				report_failure($sformatf("found expected %b actual %b",
					want.found, got.found));
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

	localparam int RANDOM_REQUESTS = 450;
	localparam int QUIET_TAIL      = 60;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     done;
	result_t  result;

	running_average_checker sb = new;
	bit allow_idle;

	per_key_running_average_table_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (done)
			sb.check_result(result);
		if (start && !busy)
			sb.note_request(request);
	end

	task automatic send_request(input opcode_t op, input logic [ID_BITS-1:0] id,
		input word_t dur);
		request_t    r;
		int unsigned gap;
		r.opcode = op;
		r.message_id = id;
		r.duration = dur;
		gap = 0;
		if (allow_idle && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 19);
		request <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (gap != 0) begin
			start <= 1'b0;
			request <= request_t'({$urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic word_t pick_duration();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return COUNT_MAX;
			2: return word_t'($urandom_range(0, 255));
			default: return word_t'($urandom);
		endcase
	endfunction

	initial begin
		opcode_t               op;
		logic [ID_BITS-1:0]    id;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		allow_idle = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_QUERY,  12'h000, 32'hDEAD_BEEF);
		send_request(OP_RECORD, 12'h000, 32'h0000_0000);
		send_request(OP_QUERY,  12'h000, 32'hFFFF_FFFF);
		send_request(OP_RECORD, 12'h000, 32'hFFFF_FFFF);
		send_request(OP_RECORD, 12'hFFF, 32'hFFFF_FFFF);
		send_request(OP_RECORD, 12'hFFF, 32'hFFFF_FFFF);
		send_request(OP_RECORD, 12'hFFF, 32'h0000_0000);
		send_request(OP_QUERY,  12'hFFF, 32'h0000_0000);
		send_request(OP_QUERY,  12'hAAA, 32'h5555_5555);
		send_request(OP_RECORD, 12'h555, 32'h0000_0001);
		send_request(OP_RECORD, 12'h555, 32'h0000_0002);
		send_request(OP_RECORD, 12'h555, 32'h0000_0002);
		send_request(OP_RECORD, 12'hAAA, 32'h8000_0000);
		send_request(OP_QUERY,  12'h555, 32'hAAAA_AAAA);
		send_request(OP_QUERY,  12'hAAA, 32'h0000_0000);
		send_request(OP_RECORD, 12'h001, 32'h7FFF_FFFF);
		send_request(OP_RECORD, 12'h001, 32'hFFFF_FFFF);
		send_request(OP_RECORD, 12'h800, 32'h0000_0001);
		send_request(OP_QUERY,  12'h800, 32'h0000_0000);

		// Most traffic lands on a dozen hot ids so their histories grow long.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			allow_idle = (i < RANDOM_REQUESTS - QUIET_TAIL);
			op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_RECORD;
			if ($urandom_range(0, 9) < 7)
				id = ID_BITS'($urandom_range(0, 11) * 341);
			else
				id = ID_BITS'($urandom);
			send_request(op, id, pick_duration());
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("per_key_running_average_table_top_tb: clean");
		else
			$display("per_key_running_average_table_top_tb: errors");
		$finish;
	end

	initial begin
		#(3_000_000);
		$display("per_key_running_average_table_top_tb: errors");
		$finish;
	end

endmodule
